// File: design/scl_pkg.sv
// Shared types and encodings for the snoop coherence line controller.
package scl_pkg;

  localparam int StateW = 4;
  localparam int AddrW  = 48;
  localparam int ReqW   = 6;
  localparam int ModeW  = 3;

  // Line states.
  localparam logic [StateW-1:0] ST_I  = 4'd0;
  localparam logic [StateW-1:0] ST_S  = 4'd1;
  localparam logic [StateW-1:0] ST_E  = 4'd2;
  localparam logic [StateW-1:0] ST_O  = 4'd3;
  localparam logic [StateW-1:0] ST_M  = 4'd4;
  localparam logic [StateW-1:0] ST_F  = 4'd5;
  localparam logic [StateW-1:0] ST_IS = 4'd6;
  localparam logic [StateW-1:0] ST_IM = 4'd7;
  localparam logic [StateW-1:0] ST_SM = 4'd8;
  localparam logic [StateW-1:0] ST_OM = 4'd9;

  // Snooped message kinds.
  localparam logic [1:0] BK_RD     = 2'd0;
  localparam logic [1:0] BK_WR     = 2'd1;
  localparam logic [1:0] BK_DATA   = 2'd2;
  localparam logic [1:0] BK_SHARED = 2'd3;

  // Cache line actions.
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_INVAL = 2'd1;
  localparam logic [1:0] ACT_RECV  = 2'd2;

  // Protocol modes.
  localparam logic [ModeW-1:0] MODE_MI    = 3'd0;
  localparam logic [ModeW-1:0] MODE_MSI   = 3'd1;
  localparam logic [ModeW-1:0] MODE_MESI  = 3'd2;
  localparam logic [ModeW-1:0] MODE_MOESI = 3'd3;
  localparam logic [ModeW-1:0] MODE_MESIF = 3'd4;

  // Action codes of an item.
  localparam logic ACTION_PROC  = 1'b0;
  localparam logic ACTION_SNOOP = 1'b1;

  typedef struct packed {
    logic [ReqW-1:0]   requester;
    logic [AddrW-1:0]  line_address;
    logic [StateW-1:0] current_state;
    logic [1:0]        bus_kind;
    logic              is_read;
    logic              action;
  } scl_item_t;

  typedef struct packed {
    logic              protocol_error;
    logic [ReqW-1:0]   bus_requester;
    logic [AddrW-1:0]  bus_address;
    logic              assert_shared;
    logic              send_line_data;
    logic              send_bus_write;
    logic              send_bus_read;
    logic [1:0]        line_action;
    logic              perm_available;
    logic [StateW-1:0] next_state;
  } scl_result_t;

endpackage

// File: design/scl_next_state.sv
// Next-state decode for one cache line under the selected coherence protocol.
module scl_next_state (
  input  logic [scl_pkg::ModeW-1:0] protocol_mode,
  input  scl_pkg::scl_item_t        item,
  output scl_pkg::scl_result_t      result
);
  import scl_pkg::*;

  logic              has_excl;
  logic              has_owned;
  logic              has_fwd;
  logic              is_mi;
  logic [StateW-1:0] cs;
  logic [1:0]        bk;
  logic              rd;
  logic              data_like;
  logic [StateW-1:0] st;
  logic              perm;
  logic [1:0]        act;
  logic              s_rd;
  logic              s_wr;
  logic              s_data;
  logic              s_shr;
  logic              err;
  logic              sent;

  // Modes above MESIF behave as MESIF.
  assign is_mi     = (protocol_mode == MODE_MI);
  assign has_excl  = (protocol_mode >= MODE_MESI);
  assign has_owned = (protocol_mode == MODE_MOESI);
  assign has_fwd   = (protocol_mode >= MODE_MESIF);

  assign cs        = item.current_state;
  assign bk        = item.bus_kind;
  assign rd        = item.is_read;
  assign data_like = (bk == BK_DATA) || (bk == BK_SHARED);

  always_comb begin
    st     = cs;
    perm   = 1'b0;
    act    = ACT_NONE;
    s_rd   = 1'b0;
    s_wr   = 1'b0;
    s_data = 1'b0;
    s_shr  = 1'b0;
    err    = 1'b0;
    if (is_mi) begin
      if (item.action == ACTION_PROC) begin
        case (cs)
          ST_I: begin
            s_wr = 1'b1;
            st   = ST_IM;
          end
          ST_M:  perm = 1'b1;
          ST_IM: st = ST_IM;
          default: begin
            st  = ST_I;
            err = 1'b1;
          end
        endcase
      end else begin
        case (cs)
          ST_I: st = ST_I;
          ST_M: begin
            s_data = 1'b1;
            act    = ACT_INVAL;
            st     = ST_I;
          end
          ST_IM: begin
            if (data_like) begin
              act = ACT_RECV;
              st  = ST_M;
            end
          end
          default: begin
            st  = ST_I;
            err = 1'b1;
          end
        endcase
      end
    end else if (item.action == ACTION_PROC) begin
      case (cs)
        ST_I: begin
          if (rd) begin
            s_rd = 1'b1;
            st   = ST_IS;
          end else begin
            s_wr = 1'b1;
            st   = ST_IM;
          end
        end
        ST_S, ST_F: begin
          if (rd) begin
            perm = 1'b1;
          end else begin
            s_wr = 1'b1;
            st   = ST_SM;
          end
        end
        ST_E: begin
          perm = 1'b1;
          st   = rd ? ST_E : ST_M;
        end
        ST_M: perm = 1'b1;
        ST_O: begin
          if (rd) begin
            perm = 1'b1;
          end else begin
            s_wr = 1'b1;
            st   = ST_OM;
          end
        end
        ST_IS, ST_IM, ST_SM, ST_OM: st = cs;
        default: begin
          st  = ST_I;
          err = 1'b1;
        end
      endcase
    end else if (cs > ST_OM) begin
      st  = ST_I;
      err = 1'b1;
    end else if (data_like) begin
      // A fill response only makes sense while a request is outstanding.
      if (cs == ST_IS) begin
        act = ACT_RECV;
        if (bk == BK_DATA) st = has_excl ? ST_E : ST_S;
        else               st = has_fwd ? ST_F : ST_S;
      end else if (cs == ST_IM || cs == ST_SM || cs == ST_OM) begin
        act = ACT_RECV;
        st  = ST_M;
      end else begin
        err = 1'b1;
      end
    end else begin
      case (cs)
        ST_I: st = ST_I;
        ST_S: begin
          if (bk == BK_RD) begin
            s_shr = 1'b1;
          end else begin
            act = ACT_INVAL;
            st  = ST_I;
          end
        end
        ST_F: begin
          if (bk == BK_RD) begin
            s_data = 1'b1;
            s_shr  = 1'b1;
            st     = ST_S;
          end else begin
            act = ACT_INVAL;
            st  = ST_I;
          end
        end
        ST_E, ST_M, ST_O: begin
          s_data = 1'b1;
          if (bk == BK_RD) begin
            s_shr = 1'b1;
            if (cs == ST_E)      st = ST_S;
            else if (cs == ST_O) st = ST_O;
            else                 st = has_owned ? ST_O : ST_S;
          end else begin
            act = ACT_INVAL;
            st  = ST_I;
          end
        end
        default: st = cs;
      endcase
    end
  end

  assign sent = s_rd || s_wr || s_data || s_shr;

  assign result.next_state     = st;
  assign result.perm_available = perm && (item.action == ACTION_PROC);
  assign result.line_action    = act;
  assign result.send_bus_read  = s_rd;
  assign result.send_bus_write = s_wr;
  assign result.send_line_data = s_data;
  assign result.assert_shared  = s_shr;
  assign result.bus_address    = sent ? item.line_address : '0;
  assign result.bus_requester  = sent ? item.requester : '0;
  assign result.protocol_error = err;

endmodule

// File: design/snoop_coherence_line_controller_top.sv
// An item passes the input register, the next-state decode, then the result register.
// Throughput: one item per cycle unless out_tready stalls the result register.
// Stage 1 takes an item while a result waits only if the input register is empty.
// Reset: rst_n is synchronous, active low; it empties both stages and sets
// protocol_mode to MI.
module snoop_coherence_line_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,   // protocol_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // current_state[3:0], line_address[51:4], requester[57:52]
  input  logic [3:0]  in_tuser,   // action[0], is_read[1], bus_kind[3:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  // next_state[3:0], perm_available[4], line_action[6:5], send_bus_read[7],
  // send_bus_write[8], send_line_data[9], assert_shared[10], bus_address[58:11],
  // bus_requester[64:59], protocol_error[65]
  output logic [71:0] out_tdata
);
  import scl_pkg::*;

  logic [ModeW-1:0] mode_r;
  logic             s1_valid_r;
  scl_item_t        s1_item_r;
  scl_item_t        item_nxt;
  logic             out_valid_r;
  scl_result_t      out_res_r;
  scl_result_t      res_nxt;
  logic             s2_load;

  assign cfg_ready = 1'b1;

  assign item_nxt.action        = in_tuser[0];
  assign item_nxt.is_read       = in_tuser[1];
  assign item_nxt.bus_kind      = in_tuser[3:2];
  assign item_nxt.current_state = in_tdata[3:0];
  assign item_nxt.line_address  = in_tdata[51:4];
  assign item_nxt.requester     = in_tdata[57:52];

  assign s2_load   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MI;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= item_nxt;
    end
  end

  scl_next_state u_next_state (
    .protocol_mode (mode_r),
    .item          (s1_item_r),
    .result        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r};

endmodule
